/* rtl/core/lbmp_pkg.sv */
package lbmp_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 16;
    localparam int WIDE_W      = 64;
    localparam int MUL_STEPS   = 2 * VAL_W;
    localparam int MCNT_W      = $clog2(MUL_STEPS + 1);
    localparam int DCNT_W      = $clog2(WIDE_W + 1);

    // operand pair for the shared multiply-reduce unit
    typedef enum logic [2:0] {
        MS_VAL_I,
        MS_PACC_BASE,
        MS_BASE_BASE,
        MS_FQ_IQ,
        MS_T_IQ,
        MS_ACC_T
    } t_msel;

    // where a finished product goes
    typedef enum logic [2:0] {
        WB_FACT,
        WB_PACC,
        WB_BASE,
        WB_INV,
        WB_T,
        WB_ACC
    } t_wb;

    typedef struct packed {
        logic  load;
        logic  zero_acc;
        logic  fact0;
        logic  pow_init;
        logic  pow_shift;
        logic  inv_init;
        logic  built_set;
        logic  div_start;
        logic  rd_a;
        logic  rd_b;
        logic  mul_start;
        t_msel msel;
        t_wb   wb;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic i_eq_p;
        logic i_zero;
        logic e_zero;
        logic e_lsb;
        logic nk_zero;
        logic dk_gt_dn;
        logic p_bad;
        logic range_bad;
        logic need_build;
        logic out_free;
    } t_stat;

endpackage

/* rtl/core/lbmp_dpath.sv */
module lbmp_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lbmp_pkg::t_cmd                  i_cmd,
    input  logic [lbmp_pkg::WIDE_W-1:0]     i_top_value,
    input  logic [lbmp_pkg::WIDE_W-1:0]     i_choose_value,
    input  logic [lbmp_pkg::VAL_W-1:0]      i_modulus,
    output lbmp_pkg::t_stat                 o_stat,
    output logic [lbmp_pkg::VAL_W-1:0]      o_residue
);

    localparam int VW = lbmp_pkg::VAL_W;
    localparam int WW = lbmp_pkg::WIDE_W;
    localparam int AW = lbmp_pkg::TBL_AW;

    logic [VW-1:0] r_fact_mem [lbmp_pkg::TABLE_DEPTH];
    logic [VW-1:0] r_invf_mem [lbmp_pkg::TABLE_DEPTH];

    logic [WW-1:0] r_n, r_k;
    logic [VW-1:0] r_p, r_dn, r_dk, r_acc, r_t, r_val, r_i, r_pacc, r_base, r_e;
    logic [VW-1:0] r_fact_q, r_invf_q, r_mrem;
    logic [VW:0]   r_built;
    logic [2*VW-1:0] r_mx;
    logic [lbmp_pkg::MCNT_W-1:0] r_mcnt;
    logic [lbmp_pkg::DCNT_W-1:0] r_dcnt;
    logic          r_mbusy, r_dbusy;
    lbmp_pkg::t_wb r_wb;

    logic [VW-1:0] mul_a, mul_b, mrem_nx, dn_nx, dk_nx;
    logic [VW:0]   mrem2, dn2, dk2;
    logic          mul_fin, qn, qk;
    logic          fact_we, invf_we;
    logic [AW-1:0] fact_wa, invf_wa, invf_ra;
    logic [VW-1:0] fact_wd, invf_wd;

    always_comb begin
        case (i_cmd.msel)
            lbmp_pkg::MS_VAL_I:     begin mul_a = r_val;    mul_b = r_i;      end
            lbmp_pkg::MS_PACC_BASE: begin mul_a = r_pacc;   mul_b = r_base;   end
            lbmp_pkg::MS_BASE_BASE: begin mul_a = r_base;   mul_b = r_base;   end
            lbmp_pkg::MS_FQ_IQ:     begin mul_a = r_fact_q; mul_b = r_invf_q; end
            lbmp_pkg::MS_T_IQ:      begin mul_a = r_t;      mul_b = r_invf_q; end
            lbmp_pkg::MS_ACC_T:     begin mul_a = r_acc;    mul_b = r_t;      end
            default:                begin mul_a = r_acc;    mul_b = r_t;      end
        endcase
    end

    // one quotient bit a cycle: restoring reduction
    assign mrem2   = {r_mrem, r_mx[2*VW-1]};
    assign mrem_nx = (mrem2 >= {1'b0, r_p}) ? VW'(mrem2 - {1'b0, r_p}) : mrem2[VW-1:0];
    assign dn2     = {r_dn, r_n[WW-1]};
    assign dk2     = {r_dk, r_k[WW-1]};
    assign qn      = dn2 >= {1'b0, r_p};
    assign qk      = dk2 >= {1'b0, r_p};
    assign dn_nx   = qn ? VW'(dn2 - {1'b0, r_p}) : dn2[VW-1:0];
    assign dk_nx   = qk ? VW'(dk2 - {1'b0, r_p}) : dk2[VW-1:0];
    assign mul_fin = r_mbusy && (r_mcnt == lbmp_pkg::MCNT_W'(1));

    assign fact_we = i_cmd.fact0 || (mul_fin && r_wb == lbmp_pkg::WB_FACT);
    assign fact_wa = i_cmd.fact0 ? '0 : AW'(r_i);
    assign fact_wd = i_cmd.fact0 ? VW'(1) : mrem_nx;
    assign invf_we = i_cmd.inv_init || (mul_fin && r_wb == lbmp_pkg::WB_INV);
    assign invf_wa = i_cmd.inv_init ? AW'(r_p - VW'(1)) : AW'(r_i - VW'(1));
    assign invf_wd = i_cmd.inv_init ? r_pacc : mrem_nx;
    assign invf_ra = i_cmd.rd_b ? AW'(r_dn - r_dk) : AW'(r_dk);

    always_ff @(posedge i_clk) begin
        if (fact_we) begin
            r_fact_mem[fact_wa] <= fact_wd;
        end
        if (i_cmd.rd_a) begin
            r_fact_q <= r_fact_mem[AW'(r_dn)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (invf_we) begin
            r_invf_mem[invf_wa] <= invf_wd;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_invf_q <= r_invf_mem[invf_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_dbusy <= 1'b0;
            r_built <= '0;
            r_mcnt  <= '0;
            r_dcnt  <= '0;
        end else begin
            if (i_cmd.built_set) begin
                r_built <= {1'b0, r_p};
            end
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= lbmp_pkg::MCNT_W'(lbmp_pkg::MUL_STEPS);
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt - lbmp_pkg::MCNT_W'(1);
                if (mul_fin) begin
                    r_mbusy <= 1'b0;
                end
            end
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= lbmp_pkg::DCNT_W'(WW);
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - lbmp_pkg::DCNT_W'(1);
                if (r_dcnt == lbmp_pkg::DCNT_W'(1)) begin
                    r_dbusy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_top_value;
            r_k   <= i_choose_value;
            r_p   <= i_modulus;
            r_acc <= VW'(1);
        end
        if (i_cmd.zero_acc) begin
            r_acc <= '0;
        end
        if (i_cmd.fact0) begin
            r_val <= VW'(1);
            r_i   <= VW'(1);
        end
        if (i_cmd.pow_init) begin
            r_base <= r_val;
            r_pacc <= VW'(1);
            r_e    <= r_p - VW'(2);
        end
        if (i_cmd.pow_shift) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.inv_init) begin
            r_val <= r_pacc;
            r_i   <= r_p - VW'(1);
        end
        if (i_cmd.div_start) begin
            r_dn <= '0;
            r_dk <= '0;
        end else if (r_dbusy) begin
            r_dn <= dn_nx;
            r_dk <= dk_nx;
            r_n  <= {r_n[WW-2:0], qn};
            r_k  <= {r_k[WW-2:0], qk};
        end
        if (i_cmd.mul_start) begin
            r_mx   <= mul_a * mul_b;
            r_mrem <= '0;
            r_wb   <= i_cmd.wb;
        end else if (r_mbusy) begin
            r_mx   <= {r_mx[2*VW-2:0], 1'b0};
            r_mrem <= mrem_nx;
        end
        if (mul_fin) begin
            case (r_wb)
                lbmp_pkg::WB_FACT: begin r_val <= mrem_nx; r_i <= r_i + VW'(1); end
                lbmp_pkg::WB_PACC: r_pacc <= mrem_nx;
                lbmp_pkg::WB_BASE: r_base <= mrem_nx;
                lbmp_pkg::WB_INV:  begin r_val <= mrem_nx; r_i <= r_i - VW'(1); end
                lbmp_pkg::WB_T:    r_t <= mrem_nx;
                lbmp_pkg::WB_ACC:  r_acc <= mrem_nx;
                default:           r_acc <= mrem_nx;
            endcase
        end
    end

    assign o_stat.mul_busy   = r_mbusy;
    assign o_stat.div_busy   = r_dbusy;
    assign o_stat.i_eq_p     = r_i == r_p;
    assign o_stat.i_zero     = r_i == '0;
    assign o_stat.e_zero     = r_e == '0;
    assign o_stat.e_lsb      = r_e[0];
    assign o_stat.nk_zero    = (r_n == '0) && (r_k == '0);
    assign o_stat.dk_gt_dn   = r_dk > r_dn;
    assign o_stat.p_bad      = r_p < VW'(2);
    assign o_stat.range_bad  = r_k[WW-1] || r_n[WW-1] || (r_n < r_k);
    assign o_stat.need_build = r_built != {1'b0, r_p};
    assign o_stat.out_free   = 1'b0;
    assign o_residue         = r_acc;

endmodule

/* rtl/core/lbmp_ctrl.sv */
module lbmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lbmp_pkg::t_stat i_stat,
    output logic            o_idle,
    output lbmp_pkg::t_cmd  o_cmd
);

    typedef enum logic [22:0] {
        S_IDLE  = 23'h000001,
        S_CHK   = 23'h000002,
        S_FACT0 = 23'h000004,
        S_FACT  = 23'h000008,
        S_FACTW = 23'h000010,
        S_POW0  = 23'h000020,
        S_POW   = 23'h000040,
        S_POWW  = 23'h000080,
        S_SQ    = 23'h000100,
        S_SQW   = 23'h000200,
        S_INV0  = 23'h000400,
        S_INV   = 23'h000800,
        S_INVW  = 23'h001000,
        S_DW    = 23'h002000,
        S_DIVW  = 23'h004000,
        S_RDA   = 23'h008000,
        S_M1    = 23'h010000,
        S_M1W   = 23'h020000,
        S_M2    = 23'h040000,
        S_M2W   = 23'h080000,
        S_M3    = 23'h100000,
        S_M3W   = 23'h200000,
        S_OUT   = 23'h400000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.msel = lbmp_pkg::MS_ACC_T;
        o_cmd.wb   = lbmp_pkg::WB_ACC;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.p_bad || i_stat.range_bad) begin
                    o_cmd.zero_acc = 1'b1;
                    n_state        = S_OUT;
                end else if (i_stat.need_build) begin
                    n_state = S_FACT0;
                end else begin
                    n_state = S_DW;
                end
            end
            S_FACT0: begin
                o_cmd.fact0 = 1'b1;
                n_state     = S_FACT;
            end
            S_FACT: begin
                if (i_stat.i_eq_p) begin
                    n_state = S_POW0;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel      = lbmp_pkg::MS_VAL_I;
                    o_cmd.wb        = lbmp_pkg::WB_FACT;
                    n_state         = S_FACTW;
                end
            end
            S_FACTW: if (!i_stat.mul_busy) n_state = S_FACT;
            S_POW0: begin
                o_cmd.pow_init = 1'b1;
                n_state        = S_POW;
            end
            S_POW: begin
                if (i_stat.e_zero) begin
                    n_state = S_INV0;
                end else if (i_stat.e_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel      = lbmp_pkg::MS_PACC_BASE;
                    o_cmd.wb        = lbmp_pkg::WB_PACC;
                    n_state         = S_POWW;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_POWW: if (!i_stat.mul_busy) n_state = S_SQ;
            S_SQ: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.pow_shift = 1'b1;
                o_cmd.msel      = lbmp_pkg::MS_BASE_BASE;
                o_cmd.wb        = lbmp_pkg::WB_BASE;
                n_state         = S_SQW;
            end
            S_SQW: if (!i_stat.mul_busy) n_state = S_POW;
            S_INV0: begin
                o_cmd.inv_init = 1'b1;
                n_state        = S_INV;
            end
            S_INV: begin
                if (i_stat.i_zero) begin
                    o_cmd.built_set = 1'b1;
                    n_state         = S_DW;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel      = lbmp_pkg::MS_VAL_I;
                    o_cmd.wb        = lbmp_pkg::WB_INV;
                    n_state         = S_INVW;
                end
            end
            S_INVW: if (!i_stat.mul_busy) n_state = S_INV;
            S_DW: begin
                if (i_stat.nk_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVW;
                end
            end
            S_DIVW: if (!i_stat.div_busy) n_state = S_RDA;
            S_RDA: begin
                if (i_stat.dk_gt_dn) begin
                    o_cmd.zero_acc = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.rd_a = 1'b1;
                    n_state    = S_M1;
                end
            end
            S_M1: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.rd_b      = 1'b1;
                o_cmd.msel      = lbmp_pkg::MS_FQ_IQ;
                o_cmd.wb        = lbmp_pkg::WB_T;
                n_state         = S_M1W;
            end
            S_M1W: if (!i_stat.mul_busy) n_state = S_M2;
            S_M2: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.msel      = lbmp_pkg::MS_T_IQ;
                o_cmd.wb        = lbmp_pkg::WB_T;
                n_state         = S_M2W;
            end
            S_M2W: if (!i_stat.mul_busy) n_state = S_M3;
            S_M3: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.msel      = lbmp_pkg::MS_ACC_T;
                o_cmd.wb        = lbmp_pkg::WB_ACC;
                n_state         = S_M3W;
            end
            S_M3W: if (!i_stat.mul_busy) n_state = S_DW;
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/lucas_binomial_mod_prime.sv */
// Flow: a query rejected in S_CHK goes straight to S_OUT; with built tables each base-p
//   digit takes one division of both operands by p, then three serial mod-multiplies.
// Queries: one at a time; a modulus change adds a table rebuild (factorials, Fermat
//   power, inverse factorials), all on the one mod-multiply unit.
// Reset (synchronous, i_rst_n low): modulus returns to 2, tables marked unbuilt,
//   controller idle, output empty. Table contents are not cleared.
module lucas_binomial_mod_prime (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration: prime modulus
    input  logic          i_cfg_wen,
    input  logic [15:0]   i_cfg_wdata,
    // query stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // [63:0] top_value, [127:64] choose_value
    // result stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [15:0]   o_m_axis_tdata    // [15:0] residue
);

    logic [lbmp_pkg::VAL_W-1:0] r_modulus;
    logic                       r_out_valid;
    logic [lbmp_pkg::VAL_W-1:0] r_out_data;
    logic [lbmp_pkg::VAL_W-1:0] residue;
    logic                       idle;
    lbmp_pkg::t_cmd             cmd;
    lbmp_pkg::t_stat            dp_stat, stat;

    // hold the modulus; the user must write it only while the block is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= lbmp_pkg::VAL_W'(2);
        end else if (i_cfg_wen) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    // accept a query whenever the controller is idle, even with a result waiting
    assign o_s_axis_tready = idle;

    // the output register frees when empty or when its transaction completes
    always_comb begin
        stat          = dp_stat;
        stat.out_free = !r_out_valid || i_m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_data <= residue;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    lbmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_axis_tvalid),
        .i_stat  (stat),
        .o_idle  (idle),
        .o_cmd   (cmd)
    );

    lbmp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_top_value    (i_s_axis_tdata[63:0]),
        .i_choose_value (i_s_axis_tdata[127:64]),
        .i_modulus      (r_modulus),
        .o_stat         (dp_stat),
        .o_residue      (residue)
    );

endmodule

/* rtl/core/lbmp_checker.sv */
module lbmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second query taken while busy");

endmodule

bind lucas_binomial_mod_prime lbmp_checker u_lbmp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
